/* hw/rtl/rpa_pkg.sv */
// ----------------------------------------------------------------------------
// rpa_pkg - shared types and constants for the ratiometric pressure averager
// Field widths, register reset values, status and command encodings.
// ----------------------------------------------------------------------------
package rpa_pkg;

	localparam int MV_W        = 12;
	localparam int CH_W        = 3;
	localparam int KPA_W       = 11;
	localparam int STAT_W      = 2;
	localparam int REG_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	// divider: dividend and quotient width, divisor width, bits per cycle
	localparam int DIV_W           = 30;
	localparam int DVS_W           = 17;
	localparam int DIV_RADIX_STEPS = 2;
	localparam int DIV_CYCLES      = DIV_W / DIV_RADIX_STEPS;

	localparam logic [REG_W-1:0] RST_SENSOR_NUM = 16'd3770;
	localparam logic [REG_W-1:0] RST_SENSOR_DEN = 16'd2640;
	localparam logic [REG_W-1:0] RST_REF_NUM    = 16'd3070;
	localparam logic [REG_W-1:0] RST_REF_DEN    = 16'd1430;
	localparam logic [KPA_W-1:0] RST_FULL_SCALE = 11'd1200;

	localparam logic [REG_W-1:0] REF_MAX    = 16'hFFFF;
	localparam logic [KPA_W-1:0] KPA_MAX    = 11'h7FF;
	localparam logic [3:0]       THRESH_DIV = 4'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENSOR_DIV_NUM = 3'd0,
		REG_SENSOR_DIV_DEN = 3'd1,
		REG_REF_DIV_NUM    = 3'd2,
		REG_REF_DIV_DEN    = 3'd3,
		REG_FULL_SCALE_KPA = 3'd4
	} cfg_reg_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_VALID    = 2'd0,
		STAT_OVERLOAD = 2'd1,
		STAT_ABSENT   = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		OP_REF    = 1'b0,
		OP_SENSOR = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		DSEL_REF_SCALE = 3'd0,
		DSEL_LO        = 3'd1,
		DSEL_HI        = 3'd2,
		DSEL_SEN_SCALE = 3'd3,
		DSEL_SAMPLE    = 3'd4,
		DSEL_MEAN      = 3'd5
	} div_sel_t;

	typedef enum logic [3:0] {
		S_CLEAR      = 4'd0,
		S_IDLE       = 4'd1,
		S_DECODE     = 4'd2,
		S_REF_WAIT   = 4'd3,
		S_LO_START   = 4'd4,
		S_LO_WAIT    = 4'd5,
		S_HI_WAIT    = 4'd6,
		S_SEN_WAIT   = 4'd7,
		S_CHECK      = 4'd8,
		S_SMP_WAIT   = 4'd9,
		S_MEM_RD     = 4'd10,
		S_UPDATE     = 4'd11,
		S_MEAN_START = 4'd12,
		S_MEAN_WAIT  = 4'd13,
		S_EMIT       = 4'd14
	} state_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     ref_wr;
		logic     lo_wr;
		logic     hi_wr;
		logic     v_wr;
		logic     sample_wr;
		logic     sample_zero;
		logic     mem_rd;
		logic     update;
		logic     set_absent;
		logic     set_overload;
		logic     set_mean;
		logic     emit;
		logic     clr;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_ref;
		logic ch_ok;
		logic mv_zero;
		logic div_done;
		logic overload;
		logic sample_zero;
		logic out_free;
	} sts_t;

endpackage

/* hw/rtl/ratiometric_pressure_averager.sv */
// ----------------------------------------------------------------------------
// ratiometric_pressure_averager - divider-scaled pressure with ring averaging
// One item in flight at a time. The shared divider does all ratio and mean
// work: up to three divisions per averaged sensor item. A finished result
// waits in the output register.
// Reset: registers to defaults, then a clearing pass over all
// CHANNELS*HISTORY_DEPTH history memory entries with s_axis_tready low.
// ----------------------------------------------------------------------------
module ratiometric_pressure_averager #(
	parameter int CHANNELS      = 5,
	parameter int HISTORY_DEPTH = 25
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rpa_pkg::REG_W-1:0]       cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [rpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // channel, millivolts, zero pad
	input  logic                            s_axis_tuser,  // opcode
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [rpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // out_channel, pressure_kpa, zero pad
	output logic [rpa_pkg::STAT_W-1:0]      m_axis_tuser   // status
);
	import rpa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	rpa_datapath #(
		.CHANNELS      (CHANNELS),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_tdata   (s_axis_tdata),
		.in_tuser   (s_axis_tuser),
		.cmd        (cmd),
		.sts        (sts),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser)
	);

	// one item at a time: busy straight after an input transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted again without a busy cycle");

	// a new result appears only from the report step
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.emit))
		else $error("output valid rose without a report step");

	// the ring update uses the old entry read in the previous cycle
	a_update_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> $past(cmd.mem_rd))
		else $error("ring update without a preceding history read");

endmodule

/* hw/rtl/rpa_div.sv */
// ----------------------------------------------------------------------------
// rpa_div - iterative unsigned divider
// Restoring division, two quotient bits per cycle; result held after done.
// ----------------------------------------------------------------------------
module rpa_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [rpa_pkg::DIV_W-1:0] dividend,
	input  logic [rpa_pkg::DVS_W-1:0] divisor,
	output logic                     done,
	output logic [rpa_pkg::DIV_W-1:0] quotient
);
	import rpa_pkg::*;

	localparam int CNT_W = $clog2(DIV_CYCLES + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DIV_W-1:0] quo_n;
	logic [DVS_W-1:0] rem_n;
	logic [DVS_W:0]   trial;

	always_comb begin
		quo_n = quo_q;
		rem_n = rem_q;
		trial = '0;
		for (int i = 0; i < DIV_RADIX_STEPS; i++) begin
			// shift the next dividend bit into the partial remainder
			trial = {rem_n, quo_n[DIV_W-1]};
			quo_n = {quo_n[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				trial    = trial - {1'b0, dvs_q};
				quo_n[0] = 1'b1;
			end
			rem_n = trial[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_CYCLES);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/rpa_datapath.sv */
// ----------------------------------------------------------------------------
// rpa_datapath - registers, history memory, operand formation and result
// Holds configuration, the reference thresholds, per-channel ring state and
// the output register; shares one divider for all ratio and mean work.
// ----------------------------------------------------------------------------
module rpa_datapath #(
	parameter int CHANNELS      = 5,
	parameter int HISTORY_DEPTH = 25
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rpa_pkg::REG_W-1:0]        cfg_data,
	input  logic [rpa_pkg::IN_TDATA_W-1:0]   in_tdata,
	input  logic                             in_tuser,
	input  rpa_pkg::cmd_t                    cmd,
	output rpa_pkg::sts_t                    sts,
	output logic                             out_tvalid,
	input  logic                             out_tready,
	output logic [rpa_pkg::OUT_TDATA_W-1:0]  out_tdata,
	output logic [rpa_pkg::STAT_W-1:0]       out_tuser
);
	import rpa_pkg::*;

	localparam int MEM_DEPTH = CHANNELS * HISTORY_DEPTH;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int PTR_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CIX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SUM_W     = $clog2(HISTORY_DEPTH * ((1 << KPA_W) - 1) + 1);

	// configuration
	logic [REG_W-1:0] snum_q, sden_q, rnum_q, rden_q;
	logic [KPA_W-1:0] fs_q;

	// captured item and working values
	opcode_t          op_q;
	logic [CH_W-1:0]  ch_q;
	logic [MV_W-1:0]  mv_q;
	logic [REG_W-1:0] ref_q, lo_q, hi_q, v_q;
	logic [KPA_W-1:0] sample_q;
	logic [KPA_W-1:0] res_press_q;
	status_t          res_stat_q;

	// per-channel state
	logic [PTR_W-1:0] ptr_q       [CHANNELS];
	logic [SUM_W-1:0] sum_q       [CHANNELS];
	logic [KPA_W-1:0] last_p_q    [CHANNELS];
	status_t          last_s_q    [CHANNELS];

	// history memory
	logic [KPA_W-1:0] hist_mem [MEM_DEPTH];
	logic [KPA_W-1:0] rd_old_q;
	logic [AW-1:0]    clr_cnt_q;

	// output register
	logic             out_valid_q;
	logic [CH_W-1:0]  out_ch_q;
	logic [KPA_W-1:0] out_press_q;
	status_t          out_stat_q;

	logic [CIX_W-1:0]   ch_idx;
	logic [AW-1:0]      addr;
	logic [PTR_W-1:0]   ptr_next;
	logic [SUM_W-1:0]   sum_new;
	logic [REG_W-1:0]   sden_eff, rden_eff, span;
	logic [REG_W-1:0]   mul_a, mul_b, addend;
	logic [2*REG_W-1:0] product;
	logic               use_mul;
	logic [DIV_W-1:0]   direct;
	logic [DIV_W-1:0]   dividend;
	logic [DVS_W-1:0]   divisor;
	logic               div_done;
	logic [DIV_W-1:0]   quo;
	logic [REG_W-1:0]   quo_sat16;
	logic [KPA_W-1:0]   quo_sat_kpa;
	logic               changed;

	assign ch_idx   = CIX_W'(ch_q);
	assign addr     = AW'(ch_idx) * AW'(HISTORY_DEPTH) + AW'(ptr_q[ch_idx]);
	assign ptr_next = (ptr_q[ch_idx] == PTR_W'(HISTORY_DEPTH - 1)) ? '0
	                  : ptr_q[ch_idx] + 1'b1;
	assign sum_new  = sum_q[ch_idx] - SUM_W'(rd_old_q) + SUM_W'(sample_q);

	// a zero denominator acts as one
	assign sden_eff = (sden_q == '0) ? REG_W'(1) : sden_q;
	assign rden_eff = (rden_q == '0) ? REG_W'(1) : rden_q;
	assign span     = hi_q - lo_q;

	// operand formation: rounded ratios use (2*a*b + d) / (2*d)
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		addend  = '0;
		use_mul = 1'b1;
		direct  = '0;
		divisor = DVS_W'(1);
		case (cmd.div_sel)
			DSEL_REF_SCALE: begin
				mul_a   = REG_W'(mv_q);
				mul_b   = rnum_q;
				addend  = rden_eff;
				divisor = {rden_eff, 1'b0};
			end
			DSEL_SEN_SCALE: begin
				mul_a   = REG_W'(mv_q);
				mul_b   = snum_q;
				addend  = sden_eff;
				divisor = {sden_eff, 1'b0};
			end
			DSEL_SAMPLE: begin
				mul_a   = v_q - lo_q;
				mul_b   = REG_W'(fs_q);
				addend  = span;
				divisor = {span, 1'b0};
			end
			DSEL_LO: begin
				use_mul = 1'b0;
				direct  = DIV_W'(ref_q);
				divisor = DVS_W'(THRESH_DIV);
			end
			DSEL_HI: begin
				use_mul = 1'b0;
				direct  = DIV_W'({ref_q, 3'b000}) + DIV_W'(ref_q);
				divisor = DVS_W'(THRESH_DIV);
			end
			DSEL_MEAN: begin
				use_mul = 1'b0;
				direct  = DIV_W'(sum_q[ch_idx]);
				divisor = DVS_W'(HISTORY_DEPTH);
			end
			default: begin
				use_mul = 1'b0;
			end
		endcase
		product  = mul_a * mul_b;
		dividend = use_mul ? (DIV_W'({product, 1'b0}) + DIV_W'(addend)) : direct;
	end

	rpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo)
	);

	assign quo_sat16   = (|quo[DIV_W-1:REG_W]) ? REF_MAX : quo[REG_W-1:0];
	assign quo_sat_kpa = (|quo[DIV_W-1:KPA_W]) ? KPA_MAX : quo[KPA_W-1:0];

	assign changed = (res_press_q != last_p_q[ch_idx]) || (res_stat_q != last_s_q[ch_idx]);

	assign sts.clr_done    = (clr_cnt_q == AW'(MEM_DEPTH - 1));
	assign sts.is_ref      = (op_q == OP_REF);
	assign sts.ch_ok       = (5'(ch_q) < 5'(CHANNELS));
	assign sts.mv_zero     = (mv_q == '0);
	assign sts.div_done    = div_done;
	assign sts.overload    = (v_q > hi_q);
	assign sts.sample_zero = (v_q < lo_q) || (span == '0);
	assign sts.out_free    = !out_valid_q || out_tready;

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snum_q      <= RST_SENSOR_NUM;
			sden_q      <= RST_SENSOR_DEN;
			rnum_q      <= RST_REF_NUM;
			rden_q      <= RST_REF_DEN;
			fs_q        <= RST_FULL_SCALE;
			ref_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				ptr_q[c]    <= '0;
				sum_q[c]    <= '0;
				last_p_q[c] <= '0;
				last_s_q[c] <= STAT_ABSENT;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_SENSOR_DIV_NUM: snum_q <= cfg_data;
					REG_SENSOR_DIV_DEN: sden_q <= cfg_data;
					REG_REF_DIV_NUM:    rnum_q <= cfg_data;
					REG_REF_DIV_DEN:    rden_q <= cfg_data;
					REG_FULL_SCALE_KPA: fs_q   <= cfg_data[KPA_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.ref_wr) begin
				ref_q <= quo_sat16;
			end
			if (cmd.lo_wr) begin
				lo_q <= quo[REG_W-1:0];
			end
			if (cmd.hi_wr) begin
				hi_q <= quo[REG_W-1:0];
			end
			if (cmd.update) begin
				sum_q[ch_idx] <= sum_new;
				ptr_q[ch_idx] <= ptr_next;
			end
			if (cmd.emit && changed) begin
				last_p_q[ch_idx] <= res_press_q;
				last_s_q[ch_idx] <= res_stat_q;
				out_valid_q      <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode_t'(in_tuser);
			ch_q <= in_tdata[CH_W-1:0];
			mv_q <= in_tdata[CH_W+MV_W-1:CH_W];
		end
		// v only matters up to the overload threshold, so saturate it
		if (cmd.v_wr) begin
			v_q <= quo_sat16;
		end
		if (cmd.sample_zero) begin
			sample_q <= '0;
		end else if (cmd.sample_wr) begin
			sample_q <= quo_sat_kpa;
		end
		if (cmd.set_absent) begin
			res_press_q <= '0;
			res_stat_q  <= STAT_ABSENT;
		end else if (cmd.set_overload) begin
			res_press_q <= '0;
			res_stat_q  <= STAT_OVERLOAD;
		end else if (cmd.set_mean) begin
			res_press_q <= quo_sat_kpa;
			res_stat_q  <= STAT_VALID;
		end
		if (cmd.emit && changed) begin
			out_ch_q    <= ch_q;
			out_press_q <= res_press_q;
			out_stat_q  <= res_stat_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			hist_mem[clr_cnt_q] <= '0;
		end else if (cmd.update) begin
			hist_mem[addr] <= sample_q;
		end
		if (cmd.mem_rd) begin
			rd_old_q <= hist_mem[addr];
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = {{(OUT_TDATA_W - CH_W - KPA_W){1'b0}}, out_press_q, out_ch_q};
	assign out_tuser  = out_stat_q;

endmodule

/* hw/rtl/rpa_ctrl.sv */
// ----------------------------------------------------------------------------
// rpa_ctrl - sequencing state machine
// Runs the clearing pass, accepts one item at a time and steps the datapath
// through scaling, threshold, sample, ring update, mean and report.
// ----------------------------------------------------------------------------
module rpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output rpa_pkg::cmd_t  cmd,
	input  rpa_pkg::sts_t  sts
);
	import rpa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_ref) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_REF_SCALE;
					state_d       = S_REF_WAIT;
				end else if (!sts.ch_ok) begin
					state_d = S_IDLE;
				end else if (sts.mv_zero) begin
					cmd.set_absent = 1'b1;
					state_d        = S_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_SEN_SCALE;
					state_d       = S_SEN_WAIT;
				end
			end
			S_REF_WAIT: begin
				if (sts.div_done) begin
					cmd.ref_wr = 1'b1;
					state_d    = S_LO_START;
				end
			end
			S_LO_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_LO;
				state_d       = S_LO_WAIT;
			end
			S_LO_WAIT: begin
				if (sts.div_done) begin
					cmd.lo_wr     = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_HI;
					state_d       = S_HI_WAIT;
				end
			end
			S_HI_WAIT: begin
				if (sts.div_done) begin
					cmd.hi_wr = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_SEN_WAIT: begin
				if (sts.div_done) begin
					cmd.v_wr = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.overload) begin
					cmd.set_overload = 1'b1;
					state_d          = S_EMIT;
				end else if (sts.sample_zero) begin
					cmd.sample_zero = 1'b1;
					state_d         = S_MEM_RD;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_SAMPLE;
					state_d       = S_SMP_WAIT;
				end
			end
			S_SMP_WAIT: begin
				if (sts.div_done) begin
					cmd.sample_wr = 1'b1;
					state_d       = S_MEM_RD;
				end
			end
			S_MEM_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_MEAN_START;
			end
			S_MEAN_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_MEAN;
				state_d       = S_MEAN_WAIT;
			end
			S_MEAN_WAIT: begin
				if (sts.div_done) begin
					cmd.set_mean = 1'b1;
					state_d      = S_EMIT;
				end
			end
			S_EMIT: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
